// ===== hw/rtl/mrwt_pkg.sv =====
`timescale 1ns / 1ps
package mrwt_pkg;
	localparam int WIDTH = 64;
	localparam int CNT_W = $clog2(WIDTH + 1);
	localparam int IDX_W = $clog2(WIDTH);

	localparam logic [2:0] VERDICT_PRIME      = 3'd0;
	localparam logic [2:0] VERDICT_ROOT       = 3'd1;
	localparam logic [2:0] VERDICT_FERMAT     = 3'd2;
	localparam logic [2:0] VERDICT_TWO        = 3'd3;
	localparam logic [2:0] VERDICT_SMALL_EVEN = 3'd4;

	typedef struct packed {
		logic [63:0] candidate;
		logic [63:0] base;
	} req_t;

	typedef struct packed {
		logic       composite;
		logic [2:0] verdict;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SPLIT,
		ST_POW_SQ,
		ST_POW_MUL,
		ST_POW_NEXT,
		ST_ROOT_SQ,
		ST_ROOT_CHK,
		ST_FINAL,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic red_start;
		logic split_step;
		logic mul_start;
		logic mul_by_base;
		logic x_from_prod;
		logic d_from_prod;
		logic init_pow;
		logic pow_dec;
		logic t_dec;
		logic x_copy;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_two;
		logic small_even;
		logic u_even;
		logic unit_busy;
		logic ebit;
		logic pow_last;
		logic t_zero;
		logic y_one;
		logic x_trivial;
	} stat_t;
endpackage

// ===== hw/rtl/mrwt_datapath.sv =====
`timescale 1ns / 1ps
module mrwt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mrwt_pkg::req_t      req,
	input  mrwt_pkg::cmd_t      cmd,
	output mrwt_pkg::stat_t     stat
);
	import mrwt_pkg::*;

	logic [WIDTH-1:0] n_q, a_q, u_q, d_q, x_q, y_q;
	logic [WIDTH-1:0] op_x_q, op_y_q, r_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] t_q;
	logic             busy_q, red_q;
	logic [WIDTH:0]   dbl, sum1;
	logic [WIDTH-1:0] r_dbl, r_add, r_next;
	logic             ybit;

	// modular doubling then conditional add, one bit per cycle
	always_comb begin
		dbl   = {r_q, 1'b0};
		r_dbl = (dbl >= {1'b0, n_q}) ? WIDTH'(dbl - {1'b0, n_q}) : dbl[WIDTH-1:0];
		ybit  = op_y_q[idx_q];
		sum1  = {1'b0, r_dbl} + {1'b0, op_x_q};
		r_add = (sum1 >= {1'b0, n_q}) ? WIDTH'(sum1 - {1'b0, n_q}) : sum1[WIDTH-1:0];
		r_next = ybit ? r_add : r_dbl;
	end

	// shared modular multiply / reduce unit; reduce is a*1 with a not reduced,
	// so it runs a bitwise remainder instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
		end else if (cmd.mul_start || cmd.red_start) begin
			busy_q <= 1'b1;
			red_q  <= cmd.red_start;
		end else if (busy_q && idx_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= req.candidate[WIDTH-1:0];
			a_q <= req.base[WIDTH-1:0];
			u_q <= req.candidate[WIDTH-1:0] - WIDTH'(1);
			t_q <= '0;
		end
		if (cmd.red_start) begin
			r_q    <= '0;
			op_x_q <= '0;
			op_y_q <= a_q;
			idx_q  <= IDX_W'(WIDTH - 1);
		end else if (cmd.mul_start) begin
			r_q    <= '0;
			op_x_q <= cmd.x_from_prod ? x_q : d_q;
			op_y_q <= cmd.mul_by_base ? a_q : (cmd.x_from_prod ? x_q : d_q);
			idx_q  <= IDX_W'(WIDTH - 1);
		end else if (busy_q) begin
			// remainder mode: shift in base bit, subtract once (r < n keeps it bounded)
			if (red_q) begin
				logic [WIDTH:0] sh;
				sh = {r_q, op_y_q[idx_q]};
				r_q <= (sh >= {1'b0, n_q}) ? WIDTH'(sh - {1'b0, n_q}) : sh[WIDTH-1:0];
			end else begin
				r_q <= r_next;
			end
			idx_q <= idx_q - IDX_W'(1);
		end
		if (cmd.red_start == 1'b0 && red_q && busy_q && idx_q == '0) begin
			a_q <= '0;
		end
		if (cmd.split_step) begin
			u_q <= u_q >> 1;
			t_q <= t_q + CNT_W'(1);
		end
		if (cmd.init_pow) begin
			a_q   <= r_q;
			d_q   <= WIDTH'(1);
		end
		if (cmd.d_from_prod) d_q <= r_q;
		if (cmd.pow_dec) u_q <= {u_q[WIDTH-2:0], 1'b0};
		if (cmd.x_copy) begin
			x_q <= d_q;
			y_q <= d_q;
		end
		if (cmd.x_from_prod) y_q <= r_q;
		if (cmd.t_dec) begin
			x_q <= y_q;
			t_q <= t_q - CNT_W'(1);
		end
	end

	// u is shifted left during exponentiation; a bit count tracks the end
	logic [CNT_W-1:0] pc_q;
	always_ff @(posedge clk) begin
		if (cmd.init_pow) pc_q <= CNT_W'(WIDTH - 1);
		else if (cmd.pow_dec) pc_q <= pc_q - CNT_W'(1);
	end

	always_comb begin
		stat.is_two     = (n_q == WIDTH'(2));
		stat.small_even = (n_q < WIDTH'(2)) || !n_q[0];
		stat.u_even     = !u_q[0];
		stat.unit_busy  = busy_q;
		stat.ebit       = u_q[WIDTH-1];
		stat.pow_last   = (pc_q == '0);
		stat.t_zero     = (t_q == '0);
		stat.y_one      = (y_q == WIDTH'(1));
		stat.x_trivial  = (x_q == WIDTH'(1)) || (x_q == n_q - WIDTH'(1));
	end
endmodule

// ===== hw/rtl/mrwt_ctrl.sv =====
`timescale 1ns / 1ps
module mrwt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output mrwt_pkg::rsp_t   rsp,
	output mrwt_pkg::cmd_t   cmd,
	input  mrwt_pkg::stat_t  stat
);
	import mrwt_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] verdict_q, verdict_d;
	logic       issued_q, issued_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			verdict_q <= VERDICT_PRIME;
			issued_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			verdict_q <= verdict_d;
			issued_q  <= issued_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		verdict_d = verdict_q;
		issued_d  = issued_q;
		cmd       = '0;
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (stat.is_two) begin
					verdict_d = VERDICT_TWO;
					state_d   = ST_DONE;
				end else if (stat.small_even) begin
					verdict_d = VERDICT_SMALL_EVEN;
					state_d   = ST_DONE;
				end else if (!issued_q) begin
					cmd.red_start = 1'b1;
					issued_d      = 1'b1;
				end else if (!stat.unit_busy) begin
					issued_d = 1'b0;
					state_d  = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (stat.u_even) begin
					cmd.split_step = 1'b1;
				end else begin
					cmd.init_pow = 1'b1;
					state_d      = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				if (!issued_q) begin
					cmd.mul_start = 1'b1;
					issued_d      = 1'b1;
				end else if (!stat.unit_busy) begin
					cmd.d_from_prod = 1'b1;
					issued_d        = 1'b0;
					state_d         = stat.ebit ? ST_POW_MUL : ST_POW_NEXT;
				end
			end
			ST_POW_MUL: begin
				if (!issued_q) begin
					cmd.mul_start   = 1'b1;
					cmd.mul_by_base = 1'b1;
					issued_d        = 1'b1;
				end else if (!stat.unit_busy) begin
					cmd.d_from_prod = 1'b1;
					issued_d        = 1'b0;
					state_d         = ST_POW_NEXT;
				end
			end
			ST_POW_NEXT: begin
				if (stat.pow_last) begin
					cmd.x_copy = 1'b1;
					state_d    = ST_ROOT_SQ;
				end else begin
					cmd.pow_dec = 1'b1;
					state_d     = ST_POW_SQ;
				end
			end
			ST_ROOT_SQ: begin
				if (stat.t_zero) begin
					state_d = ST_FINAL;
				end else if (!issued_q) begin
					cmd.mul_start   = 1'b1;
					cmd.x_from_prod = 1'b1;
					issued_d        = 1'b1;
				end else if (!stat.unit_busy) begin
					cmd.x_from_prod = 1'b1;
					issued_d        = 1'b0;
					state_d         = ST_ROOT_CHK;
				end
			end
			ST_ROOT_CHK: begin
				if (stat.y_one && !stat.x_trivial) begin
					verdict_d = VERDICT_ROOT;
					state_d   = ST_DONE;
				end else begin
					cmd.t_dec = 1'b1;
					state_d   = ST_ROOT_SQ;
				end
			end
			ST_FINAL: begin
				verdict_d = stat.y_one ? VERDICT_PRIME : VERDICT_FERMAT;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp.verdict   = verdict_q;
	assign rsp.composite = (verdict_q == VERDICT_ROOT) || (verdict_q == VERDICT_FERMAT)
		|| (verdict_q == VERDICT_SMALL_EVEN);
endmodule

// ===== hw/rtl/miller_rabin_witness_test.sv =====
`timescale 1ns / 1ps
// Work: up to (65 + t + popcount(u)) modular products on the single bit-serial unit;
//   trivial cases (2, and 0, 1 or even candidates) give a result without any product.
// Requests: one at a time; the single bit-serial modular multiplier sets the rate.
// Reset: arst_n asynchronous, active low, returns the controller to idle.
module miller_rabin_witness_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  mrwt_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output mrwt_pkg::rsp_t  out_data
);
	import mrwt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mrwt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .stat(stat)
	);

	mrwt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .rsp(out_data),
		.cmd(cmd), .stat(stat)
	);
endmodule

// ===== hw/rtl/mrwt_checker.sv =====
`timescale 1ns / 1ps
module mrwt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input mrwt_pkg::rsp_t  out_data
);
	import mrwt_pkg::*;

	// composite flag agrees with the verdict code
	a_comp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.composite == ((out_data.verdict == VERDICT_ROOT)
		|| (out_data.verdict == VERDICT_FERMAT) || (out_data.verdict == VERDICT_SMALL_EVEN))))
		else $error("composite flag mismatch");

	// one request at a time: no input taken while a result is pending
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");

	// accepted request blocks further input next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("not busy after request");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result changed under stall");
endmodule

bind miller_rabin_witness_test mrwt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
